[rtl/adsr_pkg.sv]
// Shared types and constants for the ADSR envelope generator.
// Used by adsr_ramp_unit and adsr_envelope_generator; depends on nothing.
package adsr_pkg;

    localparam int LEVEL_FRAC_BITS = 16;
    localparam int COUNT_BITS      = 24;

    // Level is Q1.LEVEL_FRAC_BITS, lengths are COUNT_BITS, the tick counter one wider
    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int LEN_W   = COUNT_BITS;
    localparam int CNT_W   = COUNT_BITS + 1;
    localparam int PROD_W  = LEVEL_W + LEN_W;
    localparam int STEP_W  = $clog2(LEVEL_W);

    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;
    localparam logic [LEN_W-1:0]   LEN_ONE    = LEN_W'(1);

    localparam logic [LEN_W-1:0] ATTACK_RST  = LEN_W'(4800);
    localparam logic [LEN_W-1:0] DECAY_RST   = LEN_W'(4800);
    localparam logic [LEN_W-1:0] RELEASE_RST = LEN_W'(4800);
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(32768);

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CFG_ATTACK_LEN    = 2'd0,
        CFG_DECAY_LEN     = 2'd1,
        CFG_SUSTAIN_LEVEL = 2'd2,
        CFG_RELEASE_LEN   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PEND
    } adsr_state_t;

    typedef enum logic [1:0] {
        RU_IDLE,
        RU_MUL,
        RU_DIV,
        RU_DONE
    } ru_state_t;

    // Request into the ramp unit: diff * count / len
    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] diff;
        logic [LEN_W-1:0]   count;
        logic [LEN_W-1:0]   len;
    } ru_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } ru_rsp_t;

endpackage

[rtl/adsr_ramp_unit.sv]
// Serial ramp arithmetic: truncated diff * count / len on one shared adder.
// Depends on adsr_pkg.
module adsr_ramp_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  adsr_pkg::ru_req_t req,
    output adsr_pkg::ru_rsp_t rsp
);
    import adsr_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEVEL_W - 1);

    ru_state_t           state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [LEVEL_W-1:0]  diff_reg, diff_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    len_reg, len_next;

    logic [PROD_W:0]     add_a;
    logic [PROD_W:0]     add_b;
    logic                add_cin;
    logic [PROD_W:0]     add_sum;

    // Shared adder: shift-add in multiply, trial subtract in divide
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            RU_MUL:
            begin
                add_a = {1'b0, acc_reg[PROD_W-2:0], 1'b0};
                if (diff_reg[LEVEL_W-1])
                begin
                    add_b = {{(PROD_W + 1 - LEN_W){1'b0}}, cnt_reg};
                end
            end
            RU_DIV:
            begin
                add_a   = {{(PROD_W - LEN_W){1'b0}}, acc_reg[PROD_W-1:LEVEL_W-1]};
                add_b   = ~{{(PROD_W + 1 - LEN_W){1'b0}}, len_reg};
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
        add_sum = add_a + add_b + {{PROD_W{1'b0}}, add_cin};
    end

    // Sequencer: one multiply step or one quotient bit per cycle
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        diff_next  = diff_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        rsp.done     = 1'b0;
        rsp.quotient = acc_reg[LEVEL_W-1:0];
        case (state_reg)
            RU_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = '0;
                    step_next  = '0;
                    diff_next  = req.diff;
                    cnt_next   = req.count;
                    len_next   = req.len;
                    state_next = RU_MUL;
                end
            end
            RU_MUL:
            begin
                acc_next  = add_sum[PROD_W-1:0];
                diff_next = {diff_reg[LEVEL_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = RU_DIV;
                end
            end
            RU_DIV:
            begin
                if (!add_sum[PROD_W])
                begin
                    acc_next = {add_sum[LEN_W-1:0], acc_reg[LEVEL_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = RU_DONE;
                end
            end
            RU_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = RU_IDLE;
            end
            default:
            begin
                state_next = RU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RU_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        cnt_reg  <= cnt_next;
        len_reg  <= len_next;
    end

endmodule

[rtl/adsr_envelope_generator.sv]
// Linear ADSR envelope generator top level: tick handling, phases, config, output.
// Depends on adsr_pkg and adsr_ramp_unit.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  gate
//   out      output     out_valid / out_stall level, phase_out
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A ramp tick goes from input transfer to result through start, 17 multiply
// steps and 17 quotient steps on the shared adder in adsr_ramp_unit, finish
// and output load. Sustain and off ticks skip the ramp unit. One tick is in
// flight at a time; in_stall is high until the result sits in the output
// register, which holds it under out_stall while the next tick is accepted.
// Reset is asynchronous and active low; cfg_ready is always high and
// registers are meant to be written while idle.
module adsr_envelope_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         gate,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [adsr_pkg::LEVEL_W-1:0] level,
    output logic [2:0]                   phase_out,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [adsr_pkg::LEN_W-1:0]   cfg_data
);
    import adsr_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]   attack_len_reg;
    logic [LEN_W-1:0]   decay_len_reg;
    logic [LEVEL_W-1:0] sustain_level_reg;
    logic [LEN_W-1:0]   release_len_reg;

    // Envelope state
    adsr_state_t        state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   tick_count_reg, tick_count_next;
    logic [LEVEL_W-1:0] ramp_start_reg, ramp_start_next;
    logic [LEVEL_W-1:0] last_level_reg, last_level_next;
    logic               last_gate_reg, last_gate_next;

    // Work in flight and results
    logic [LEVEL_W-1:0] ramp_ref_reg, ramp_ref_next;
    logic               ramp_up_reg, ramp_up_next;
    logic [LEVEL_W-1:0] res_level_reg, res_level_next;
    phase_t             res_phase_reg, res_phase_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    phase_t             out_phase_reg, out_phase_next;
    ru_req_t            req_reg, req_next;
    ru_rsp_t            rsp;

    // Per-tick decode
    logic               in_xfer;
    logic               rise, fall;
    phase_t             ph_e;
    logic [CNT_W-1:0]   cnt_e;
    logic [LEVEL_W-1:0] ref_e;
    logic [LEVEL_W-1:0] sus_eff;
    logic [LEVEL_W-1:0] target;
    logic [LEN_W-1:0]   len_sel;
    logic [LEN_W-1:0]   len_eff;
    phase_t             end_phase;
    logic [LEVEL_W-1:0] end_ref;
    logic               is_ramp;
    logic [CNT_W-1:0]   cnt_inc;
    logic               ramp_end;
    logic [LEN_W-1:0]   cnt_sat;
    logic               out_free;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign level     = out_level_reg;
    assign phase_out = out_phase_reg;
    assign cfg_ready = 1'b1;

    // Decode the incoming tick against the current phase
    always_comb
    begin
        rise    = !last_gate_reg && gate;
        fall    = last_gate_reg && !gate;
        ph_e    = rise ? PH_ATTACK : (fall ? PH_RELEASE : phase_reg);
        cnt_e   = (rise || fall) ? '0 : tick_count_reg;
        ref_e   = (rise || fall) ? last_level_reg : ramp_start_reg;
        sus_eff = (sustain_level_reg > FULL_SCALE) ? FULL_SCALE : sustain_level_reg;

        target    = LEVEL_ZERO;
        len_sel   = LEN_ONE;
        end_phase = PH_OFF;
        end_ref   = ref_e;
        is_ramp   = 1'b0;
        case (ph_e)
            PH_ATTACK:
            begin
                target    = FULL_SCALE;
                len_sel   = attack_len_reg;
                end_phase = PH_DECAY;
                end_ref   = FULL_SCALE;
                is_ramp   = 1'b1;
            end
            PH_DECAY:
            begin
                target    = sus_eff;
                len_sel   = decay_len_reg;
                end_phase = PH_SUSTAIN;
                end_ref   = sus_eff;
                is_ramp   = 1'b1;
            end
            PH_RELEASE:
            begin
                target    = LEVEL_ZERO;
                len_sel   = release_len_reg;
                end_phase = PH_OFF;
                end_ref   = ref_e;
                is_ramp   = 1'b1;
            end
            default:
            begin
                is_ramp = 1'b0;
            end
        endcase

        // Zero length acts as one; count saturates at the length
        len_eff  = (len_sel == '0) ? LEN_ONE : len_sel;
        cnt_inc  = cnt_e + CNT_W'(1);
        ramp_end = (cnt_inc > {1'b0, len_eff}) || (cnt_inc == '0);
        cnt_sat  = (cnt_e > {1'b0, len_eff}) ? len_eff : cnt_e[LEN_W-1:0];
    end

    // Sequencer: accept a tick, wait on the ramp unit, hand off the result
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        ramp_start_next = ramp_start_reg;
        last_level_next = last_level_reg;
        last_gate_next  = last_gate_reg;
        ramp_ref_next   = ramp_ref_reg;
        ramp_up_next    = ramp_up_reg;
        res_level_next  = res_level_reg;
        res_phase_next  = res_phase_reg;
        out_valid_next  = out_valid_reg;
        out_level_next  = out_level_reg;
        out_phase_next  = out_phase_reg;
        req_next        = req_reg;
        req_next.start  = 1'b0;

        // Drop the output once it is transferred
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    last_gate_next = gate;
                    if (is_ramp)
                    begin
                        tick_count_next = ramp_end ? '0 : cnt_inc;
                        phase_next      = ramp_end ? end_phase : ph_e;
                        ramp_start_next = ramp_end ? end_ref : ref_e;
                        res_phase_next  = ramp_end ? end_phase : ph_e;
                        ramp_ref_next   = ref_e;
                        ramp_up_next    = (target >= ref_e);
                        req_next.start  = 1'b1;
                        req_next.diff   = (target >= ref_e) ? (target - ref_e)
                                                            : (ref_e - target);
                        req_next.count  = cnt_sat;
                        req_next.len    = len_eff;
                        state_next      = ST_RUN;
                    end
                    else
                    begin
                        tick_count_next = cnt_e;
                        phase_next      = ph_e;
                        ramp_start_next = ref_e;
                        res_phase_next  = ph_e;
                        if (ph_e == PH_SUSTAIN)
                        begin
                            res_level_next  = sus_eff;
                            last_level_next = sus_eff;
                        end
                        else
                        begin
                            res_level_next = LEVEL_ZERO;
                        end
                        state_next = ST_PEND;
                    end
                end
            end
            ST_RUN:
            begin
                if (rsp.done)
                begin
                    res_level_next  = ramp_up_reg ? (ramp_ref_reg + rsp.quotient)
                                                  : (ramp_ref_reg - rsp.quotient);
                    last_level_next = res_level_next;
                    state_next      = ST_PEND;
                end
            end
            ST_PEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = res_level_reg;
                    out_phase_next = res_phase_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control, envelope state and the ramp unit request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_OFF;
            tick_count_reg <= '0;
            ramp_start_reg <= '0;
            last_level_reg <= '0;
            last_gate_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            req_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            ramp_start_reg <= ramp_start_next;
            last_level_reg <= last_level_next;
            last_gate_reg  <= last_gate_next;
            out_valid_reg  <= out_valid_next;
            req_reg        <= req_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ramp_ref_reg  <= ramp_ref_next;
        ramp_up_reg   <= ramp_up_next;
        res_level_reg <= res_level_next;
        res_phase_reg <= res_phase_next;
        out_level_reg <= out_level_next;
        out_phase_reg <= out_phase_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg    <= ATTACK_RST;
            decay_len_reg     <= DECAY_RST;
            sustain_level_reg <= SUSTAIN_RST;
            release_len_reg   <= RELEASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ATTACK_LEN:    attack_len_reg    <= cfg_data;
                CFG_DECAY_LEN:     decay_len_reg     <= cfg_data;
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_RELEASE_LEN:   release_len_reg   <= cfg_data;
                default:           attack_len_reg    <= attack_len_reg;
            endcase
        end
    end

    adsr_ramp_unit u_ramp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // Output level never exceeds full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level <= FULL_SCALE))
        else $error("level above full scale");

    // Off phase always reports a zero level
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (phase_out == PH_OFF)) |-> (level == LEVEL_ZERO))
        else $error("nonzero level in off phase");

    // Ramp unit finishes only while a ramp tick is in flight
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == ST_RUN))
        else $error("ramp unit done outside a ramp tick");

    // An accepted tick closes the input until its result is handed off
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("input open right after a transfer");

endmodule
